/* hw/rtl/lsra_pkg.sv */
// ============================================================================
// lsra_pkg
// Shared types and constants for the linear scan register assigner.
// ============================================================================
package lsra_pkg;

  // default structure sizes
  localparam int MAX_REGS_DEF      = 16;
  localparam int MAX_TEMPS_DEF     = 4096;
  localparam int POSITION_BITS_DEF = 16;

  // fixed field widths
  localparam int TEMP_W    = 12;
  localparam int REG_W     = 6;
  localparam int OFFSET_W  = 16;
  localparam int SPILLS_W  = 13;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;

  // largest spill slot in bytes
  localparam logic [CFG_W-1:0] SLOT_BYTES_MAX = 5'd16;

  // configuration reset values
  localparam logic [CFG_W-1:0] RST_REG_COUNT  = 5'd10;
  localparam logic [CFG_W-1:0] RST_BASE_REG   = 5'd2;
  localparam logic [CFG_W-1:0] RST_SLOT_BYTES = 5'd8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REG_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_REG   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_BYTES = 2'd2;

  // command broadcast to every cell of the active list
  typedef struct packed {
    logic shift_left;
    logic insert;
  } cell_cmd_t;

  // command to the spill slot unit
  typedef struct packed {
    logic clear;
    logic take;
  } slot_cmd_t;

endpackage

/* hw/rtl/lsra_in_if.sv */
// ============================================================================
// lsra_in_if
// Live interval channel: valid/ready handshake with the interval fields.
// ============================================================================
interface lsra_in_if
  import lsra_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) ();
  logic                     valid;
  logic                     ready;
  logic                     begin_function;
  logic                     eligible;
  logic [TEMP_W-1:0]        temp_id;
  logic [POSITION_BITS-1:0] def_position;
  logic [POSITION_BITS-1:0] use_position;
  logic                     must_spill;

  modport source (
    output valid, begin_function, eligible, temp_id, def_position, use_position,
           must_spill,
    input  ready
  );
  modport sink (
    input  valid, begin_function, eligible, temp_id, def_position, use_position,
           must_spill,
    output ready
  );
endinterface

/* hw/rtl/lsra_out_if.sv */
// ============================================================================
// lsra_out_if
// Assignment channel: valid/ready handshake with the assignment fields.
// ============================================================================
interface lsra_out_if
  import lsra_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [TEMP_W-1:0]   out_temp;
  logic                has_register;
  logic [REG_W-1:0]    register_number;
  logic [OFFSET_W-1:0] slot_offset;
  logic [SPILLS_W-1:0] spills_so_far;
  logic                last;

  modport source (
    output valid, out_temp, has_register, register_number, slot_offset,
           spills_so_far, last,
    input  ready
  );
  modport sink (
    input  valid, out_temp, has_register, register_number, slot_offset,
           spills_so_far, last,
    output ready
  );
endinterface

/* hw/rtl/lsra_cell.sv */
// ============================================================================
// lsra_cell
// One entry of the active list, kept sorted by end position along the chain.
// Shifts left on expiry, takes its left neighbour or the new entry on insert.
// ============================================================================
module lsra_cell
  import lsra_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                     clk,
  input  cell_cmd_t                cmd,
  input  logic                     occupied,
  input  logic [POSITION_BITS-1:0] new_end,
  input  logic [TEMP_W-1:0]        new_temp,
  input  logic [REG_W-1:0]         new_reg,
  input  logic                     left_past,
  input  logic [POSITION_BITS-1:0] left_end,
  input  logic [TEMP_W-1:0]        left_temp,
  input  logic [REG_W-1:0]         left_reg,
  input  logic [POSITION_BITS-1:0] right_end,
  input  logic [TEMP_W-1:0]        right_temp,
  input  logic [REG_W-1:0]         right_reg,
  output logic                     past,
  output logic [POSITION_BITS-1:0] end_q,
  output logic [TEMP_W-1:0]        temp_q,
  output logic [REG_W-1:0]         reg_q
);

  logic [POSITION_BITS-1:0] end_pos_r;
  logic [TEMP_W-1:0]        temp_r;
  logic [REG_W-1:0]         reg_r;

  // the new entry belongs at or before this cell
  assign past = !occupied || (end_pos_r > new_end);

  // entry update
  always_ff @(posedge clk) begin
    if (cmd.shift_left) begin
      end_pos_r <= right_end;
      temp_r    <= right_temp;
      reg_r     <= right_reg;
    end else if (cmd.insert && past) begin
      if (left_past) begin
        end_pos_r <= left_end;
        temp_r    <= left_temp;
        reg_r     <= left_reg;
      end else begin
        end_pos_r <= new_end;
        temp_r    <= new_temp;
        reg_r     <= new_reg;
      end
    end
  end

  assign end_q  = end_pos_r;
  assign temp_q = temp_r;
  assign reg_q  = reg_r;

endmodule

/* hw/rtl/lsra_slot.sv */
// ============================================================================
// lsra_slot
// Spill slot allocator: saturating slot counter and byte offset of the slot.
// ============================================================================
module lsra_slot
  import lsra_pkg::*;
#(
  parameter int MAX_TEMPS = MAX_TEMPS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  slot_cmd_t           cmd,
  input  logic [CFG_W-1:0]    slot_bytes,
  output logic [OFFSET_W-1:0] offset,
  output logic [SPILLS_W-1:0] spills_now,
  output logic [SPILLS_W-1:0] spills_next
);

  localparam int CNT_W  = $clog2(MAX_TEMPS + 1);
  localparam int IDX_W  = $clog2(MAX_TEMPS);
  localparam int PROD_W = IDX_W + CFG_W;

  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic [CNT_W-1:0]  cnt_inc;
  logic [IDX_W-1:0]  idx;
  logic [CFG_W-1:0]  sb;
  logic [PROD_W-1:0] prod;

  // clamp the slot size
  always_comb begin
    if (slot_bytes == '0) begin
      sb = 5'd1;
    end else if (slot_bytes > SLOT_BYTES_MAX) begin
      sb = SLOT_BYTES_MAX;
    end else begin
      sb = slot_bytes;
    end
  end

  // saturating slot index and count
  assign idx     = (cnt_r > CNT_W'(MAX_TEMPS - 1)) ? IDX_W'(MAX_TEMPS - 1)
                                                   : IDX_W'(cnt_r);
  assign cnt_inc = (cnt_r != CNT_W'(MAX_TEMPS)) ? cnt_r + 1'b1 : cnt_r;

  // byte offset of the slot handed out next
  assign prod   = PROD_W'(idx) * PROD_W'(sb);
  assign offset = OFFSET_W'(prod);

  assign spills_now  = SPILLS_W'(cnt_r);
  assign spills_next = SPILLS_W'(cnt_inc);

  always_comb begin
    if (cmd.clear) begin
      cnt_nxt = '0;
    end else if (cmd.take) begin
      cnt_nxt = cnt_inc;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* hw/rtl/linear_scan_register_assigner.sv */
// ============================================================================
// linear_scan_register_assigner
// Linear scan register assignment over a chain of active list cells.
//
//   channel  | direction | handshake       | carries
//   ---------+-----------+-----------------+---------------------------------
//   in_ch    | in        | valid/ready     | one live interval
//   out_ch   | out       | valid/ready     | one assignment (up to 2 per item)
//   cfg_*    | in        | write enable    | register count, base, slot size
//
// An interval is accepted in the idle state; in the work state the chain
// then retires each expired active entry from the head, shifting one place
// per entry, and then decides. An eviction adds a victim state for the
// second assignment, which reports the evicted interval as spilled.
// Deciding waits while the output holds an assignment not yet taken.
// Reset is synchronous and active low; it sets control state and configuration only.
// ============================================================================
module linear_scan_register_assigner
  import lsra_pkg::*;
#(
  parameter int MAX_REGS      = MAX_REGS_DEF,
  parameter int MAX_TEMPS     = MAX_TEMPS_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  lsra_in_if.sink              in_ch,
  lsra_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int IDX_W = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
  localparam int CNT_W = $clog2(MAX_REGS + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_WORK   = 2'd1;
  localparam logic [1:0] S_VICTIM = 2'd2;

  // configuration
  logic [CFG_W-1:0] reg_count_r;
  logic [CFG_W-1:0] base_r;
  logic [CFG_W-1:0] slot_bytes_r;

  // control state
  logic [1:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [MAX_REGS-1:0] free_r, free_nxt;

  // current interval
  logic [TEMP_W-1:0]        temp_r;
  logic [POSITION_BITS-1:0] start_r;
  logic [POSITION_BITS-1:0] stop_r;
  logic                     spill_r;
  logic [TEMP_W-1:0]        victim_r, victim_nxt;
  logic                     in_fire;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [TEMP_W-1:0]   o_temp_r, o_temp_nxt;
  logic                o_hasreg_r, o_hasreg_nxt;
  logic [REG_W-1:0]    o_reg_r, o_reg_nxt;
  logic [OFFSET_W-1:0] o_off_r, o_off_nxt;
  logic [SPILLS_W-1:0] o_spills_r, o_spills_nxt;
  logic                o_last_r, o_last_nxt;
  logic                out_free;
  logic                emit;

  // chain of cells
  cell_cmd_t                cmd;
  logic [REG_W-1:0]         new_reg;
  logic [CNT_W-1:0]         count_eff;
  logic [MAX_REGS-1:0]      occ;
  logic [MAX_REGS-1:0]      past;
  logic [POSITION_BITS-1:0] cell_end  [MAX_REGS];
  logic [TEMP_W-1:0]        cell_temp [MAX_REGS];
  logic [REG_W-1:0]         cell_reg  [MAX_REGS];

  // decision terms
  logic [IDX_W-1:0]    tail_idx;
  logic [5:0]          nregs;
  logic [MAX_REGS-1:0] range_mask;
  logic [MAX_REGS-1:0] avail;
  logic [IDX_W-1:0]    grant_idx;
  logic [REG_W-1:0]    grant_reg;
  logic [5:0]          fbit;
  logic                head_exp;
  logic                grant_ok;
  logic                evict_ok;
  slot_cmd_t           slot_cmd;
  logic [OFFSET_W-1:0] slot_off;
  logic [SPILLS_W-1:0] spills_now;
  logic [SPILLS_W-1:0] spills_next;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_count_r  <= RST_REG_COUNT;
      base_r       <= RST_BASE_REG;
      slot_bytes_r <= RST_SLOT_BYTES;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REG_COUNT:  reg_count_r  <= cfg_wdata;
        CFG_BASE_REG:   base_r       <= cfg_wdata;
        CFG_SLOT_BYTES: slot_bytes_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input transfer
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && (state_r == S_IDLE);
  assign out_free    = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      temp_r  <= in_ch.temp_id;
      start_r <= in_ch.def_position;
      stop_r  <= (in_ch.use_position > in_ch.def_position) ? in_ch.use_position
                                                           : in_ch.def_position;
      spill_r <= in_ch.must_spill;
    end
    victim_r <= victim_nxt;
  end

  // usable register count and lowest free register
  always_comb begin
    if (reg_count_r == '0) begin
      nregs = 6'd1;
    end else if (6'(reg_count_r) > 6'(MAX_REGS)) begin
      nregs = 6'(MAX_REGS);
    end else begin
      nregs = 6'(reg_count_r);
    end
    for (int k = 0; k < MAX_REGS; k++) begin
      range_mask[k] = 6'(k) < nregs;
    end
  end

  assign avail = free_r & range_mask;

  always_comb begin
    grant_idx = '0;
    for (int k = MAX_REGS - 1; k >= 0; k--) begin
      if (avail[k]) begin
        grant_idx = IDX_W'(k);
      end
    end
  end

  assign grant_reg = 6'(base_r) + 6'(grant_idx);
  assign tail_idx  = IDX_W'(count_r - 1'b1);
  assign fbit      = cell_reg[0] - 6'(base_r);
  assign head_exp  = (count_r != '0) && (cell_end[0] < start_r);
  assign grant_ok  = (count_r < CNT_W'(MAX_REGS)) && (avail != '0);
  assign evict_ok  = (count_r != '0) && (cell_end[tail_idx] > stop_r);

  // sequencing of expiry, decision and eviction
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    free_nxt       = free_r;
    victim_nxt     = victim_r;
    cmd            = '0;
    new_reg        = grant_reg;
    count_eff      = count_r;
    slot_cmd       = '0;
    emit           = 1'b0;
    o_temp_nxt     = temp_r;
    o_hasreg_nxt   = 1'b0;
    o_reg_nxt      = '0;
    o_off_nxt      = '0;
    o_spills_nxt   = spills_now;
    o_last_nxt     = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_ch.begin_function) begin
            count_nxt      = '0;
            free_nxt       = '1;
            slot_cmd.clear = 1'b1;
          end
          state_nxt = in_ch.eligible ? S_WORK : S_IDLE;
        end
      end
      S_WORK: begin
        if (head_exp) begin
          // retire the head entry and free its register
          cmd.shift_left = 1'b1;
          count_nxt      = count_r - 1'b1;
          if (fbit < 6'(MAX_REGS)) begin
            free_nxt[fbit[IDX_W-1:0]] = 1'b1;
          end
        end else if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
          priority if (spill_r) begin
            slot_cmd.take = 1'b1;
            o_off_nxt     = slot_off;
            o_spills_nxt  = spills_next;
          end else if (grant_ok) begin
            cmd.insert          = 1'b1;
            count_nxt           = count_r + 1'b1;
            free_nxt[grant_idx] = 1'b0;
            o_hasreg_nxt        = 1'b1;
            o_reg_nxt           = grant_reg;
          end else if (evict_ok) begin
            // tail leaves, new interval takes its register
            cmd.insert   = 1'b1;
            count_eff    = count_r - 1'b1;
            new_reg      = cell_reg[tail_idx];
            victim_nxt   = cell_temp[tail_idx];
            o_hasreg_nxt = 1'b1;
            o_reg_nxt    = cell_reg[tail_idx];
            o_last_nxt   = 1'b0;
            state_nxt    = S_VICTIM;
          end else begin
            slot_cmd.take = 1'b1;
            o_off_nxt     = slot_off;
            o_spills_nxt  = spills_next;
          end
        end
      end
      S_VICTIM: begin
        if (out_free) begin
          emit          = 1'b1;
          slot_cmd.take = 1'b1;
          o_temp_nxt    = victim_r;
          o_off_nxt     = slot_off;
          o_spills_nxt  = spills_next;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // occupancy seen by the cells during an insert
  always_comb begin
    for (int k = 0; k < MAX_REGS; k++) begin
      occ[k] = CNT_W'(k) < count_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      free_r  <= '1;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      free_r  <= free_nxt;
    end
  end

  // output register
  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_temp_r   <= o_temp_nxt;
      o_hasreg_r <= o_hasreg_nxt;
      o_reg_r    <= o_reg_nxt;
      o_off_r    <= o_off_nxt;
      o_spills_r <= o_spills_nxt;
      o_last_r   <= o_last_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.out_temp        = o_temp_r;
  assign out_ch.has_register    = o_hasreg_r;
  assign out_ch.register_number = o_reg_r;
  assign out_ch.slot_offset     = o_off_r;
  assign out_ch.spills_so_far   = o_spills_r;
  assign out_ch.last            = o_last_r;

  // spill slot unit
  lsra_slot #(
    .MAX_TEMPS (MAX_TEMPS)
  ) u_slot (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (slot_cmd),
    .slot_bytes  (slot_bytes_r),
    .offset      (slot_off),
    .spills_now  (spills_now),
    .spills_next (spills_next)
  );

  // active list cells, head at index 0
  for (genvar k = 0; k < MAX_REGS; k++) begin : g_cell
    localparam int L = (k == 0) ? 0 : k - 1;
    localparam int R = (k == MAX_REGS - 1) ? k : k + 1;

    lsra_cell #(
      .POSITION_BITS (POSITION_BITS)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .occupied   (occ[k]),
      .new_end    (stop_r),
      .new_temp   (temp_r),
      .new_reg    (new_reg),
      .left_past  ((k == 0) ? 1'b0 : past[L]),
      .left_end   (cell_end[L]),
      .left_temp  (cell_temp[L]),
      .left_reg   (cell_reg[L]),
      .right_end  (cell_end[R]),
      .right_temp (cell_temp[R]),
      .right_reg  (cell_reg[R]),
      .past       (past[k]),
      .end_q      (cell_end[k]),
      .temp_q     (cell_temp[k]),
      .reg_q      (cell_reg[k])
    );
  end

endmodule

/* tb/tb_linear_scan_register_assigner.sv */
// ============================================================================
// tb_linear_scan_register_assigner
// Self-checking bench for the linear scan register assigner. Intervals go in
// over the input channel, a scoreboard class predicts every assignment
// (grants, forced spills, evictions, spill slot offsets and counts) and
// checks each output transfer in order. Directed intervals come first, then
// random functions under several register settings and idling patterns, then
// a run of forced spills back to back.
// ============================================================================
`timescale 1ns / 100ps

module tb_linear_scan_register_assigner;
  import lsra_pkg::*;

  localparam int CLK_HALF   = 6;
  localparam int RST_CYCLES = 10;
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE     = 40;
  localparam int PHASES     = 8;
  localparam int PHASE_ITEMS = 170;
  localparam int FLOOD_ITEMS = 180;
  localparam int POS_W      = POSITION_BITS_DEF;
  localparam int POS_MAX    = (1 << POS_W) - 1;

  // one live interval as the feeder presents it
  typedef struct {
    logic              begin_function;
    logic              eligible;
    logic [TEMP_W-1:0] temp_id;
    logic [POS_W-1:0]  def_position;
    logic [POS_W-1:0]  use_position;
    logic              must_spill;
  } interval_t;

  // one assignment as the block reports it
  typedef struct packed {
    logic [TEMP_W-1:0]   out_temp;
    logic                has_register;
    logic [REG_W-1:0]    register_number;
    logic [OFFSET_W-1:0] slot_offset;
    logic [SPILLS_W-1:0] spills_so_far;
    logic                last;
  } assignment_t;

  // register settings and idling per random phase
  int unsigned count_tab [PHASES] = '{10, 16, 1, 31, 0, 4, 2, 8};
  int unsigned base_tab  [PHASES] = '{2, 0, 31, 17, 5, 9, 28, 0};
  int unsigned bytes_tab [PHASES] = '{8, 16, 1, 31, 0, 3, 12, 5};
  int unsigned gap_tab   [PHASES] = '{0, 64, 0, 16, 0, 64, 0, 16};
  int unsigned stall_tab [PHASES] = '{0, 0, 64, 16, 0, 0, 64, 16};

  // --------------------------------------------------------------------------
  // assignment predictor and in-order checker
  // --------------------------------------------------------------------------
  class lsra_scoreboard;
    logic [CFG_W-1:0]    reg_count;
    logic [CFG_W-1:0]    base_reg;
    logic [CFG_W-1:0]    slot_bytes;
    logic [POS_W-1:0]    live_end  [MAX_REGS_DEF];
    logic [TEMP_W-1:0]   live_temp [MAX_REGS_DEF];
    logic [REG_W-1:0]    live_reg  [MAX_REGS_DEF];
    int                  live_count;
    logic [MAX_REGS_DEF-1:0] free_map;
    int                  spill_count;
    assignment_t         expected_q [$];
    int                  mismatches;

    function new();
      reg_count  = RST_REG_COUNT;
      base_reg   = RST_BASE_REG;
      slot_bytes = RST_SLOT_BYTES;
      mismatches = 0;
      clear_function();
    endfunction

    function void clear_function();
      live_count  = 0;
      free_map    = '1;
      spill_count = 0;
    endfunction

    function void write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      case (idx)
        CFG_REG_COUNT:  reg_count  = value;
        CFG_BASE_REG:   base_reg   = value;
        CFG_SLOT_BYTES: slot_bytes = value;
        default: ;
      endcase
    endfunction

    // next slot offset; counter and slot index both saturate
    function logic [OFFSET_W-1:0] take_slot();
      int idx;
      int bytes;
      idx   = (spill_count > MAX_TEMPS_DEF - 1) ? MAX_TEMPS_DEF - 1 : spill_count;
      bytes = (slot_bytes == 0) ? 1 : (slot_bytes > SLOT_BYTES_MAX) ? SLOT_BYTES_MAX
                                                                   : slot_bytes;
      if (spill_count < MAX_TEMPS_DEF) spill_count++;
      return OFFSET_W'(idx * bytes);
    endfunction

    function void push(logic [TEMP_W-1:0] temp, logic granted, logic [REG_W-1:0] regn,
                       logic [OFFSET_W-1:0] offset, logic final_one);
      assignment_t a;
      a.out_temp        = temp;
      a.has_register    = granted;
      a.register_number = granted ? regn : '0;
      a.slot_offset     = granted ? '0 : offset;
      a.spills_so_far   = SPILLS_W'(spill_count);
      a.last            = final_one;
      expected_q.push_back(a);
    endfunction

    // keep the live list ordered by end, new entry after equal ends
    function void insert_live(logic [POS_W-1:0] fin, logic [TEMP_W-1:0] temp,
                              logic [REG_W-1:0] regn);
      int at;
      if (live_count >= MAX_REGS_DEF) return;
      at = live_count;
      for (int r = 0; r < live_count; r++) begin
        if (live_end[r] > fin) begin
          at = r;
          break;
        end
      end
      for (int r = live_count; r > at; r--) begin
        live_end[r]  = live_end[r-1];
        live_temp[r] = live_temp[r-1];
        live_reg[r]  = live_reg[r-1];
      end
      live_end[at]  = fin;
      live_temp[at] = temp;
      live_reg[at]  = regn;
      live_count++;
    endfunction

    function void note_interval(interval_t iv);
      logic [POS_W-1:0]    fin;
      logic [5:0]          free_idx;
      logic [REG_W-1:0]    regn;
      logic [TEMP_W-1:0]   victim;
      logic [OFFSET_W-1:0] offset;
      int                  nregs;
      int                  w;
      fin = (iv.use_position > iv.def_position) ? iv.use_position : iv.def_position;
      if (iv.begin_function) clear_function();
      if (!iv.eligible) return;
      nregs = (reg_count == 0) ? 1 : (reg_count > MAX_REGS_DEF) ? MAX_REGS_DEF : reg_count;

      // release entries that ended before the new start
      w = 0;
      for (int r = 0; r < live_count; r++) begin
        if (live_end[r] < iv.def_position) begin
          free_idx = live_reg[r] - {1'b0, base_reg};
          if (free_idx < MAX_REGS_DEF) free_map[free_idx] = 1'b1;
        end else begin
          live_end[w]  = live_end[r];
          live_temp[w] = live_temp[r];
          live_reg[w]  = live_reg[r];
          w++;
        end
      end
      live_count = w;

      if (iv.must_spill) begin
        offset = take_slot();
        push(iv.temp_id, 1'b0, '0, offset, 1'b1);
        return;
      end

      // lowest free register
      if (live_count < MAX_REGS_DEF) begin
        for (int k = 0; k < nregs; k++) begin
          if (free_map[k]) begin
            regn = REG_W'(base_reg + k);
            free_map[k] = 1'b0;
            insert_live(fin, iv.temp_id, regn);
            push(iv.temp_id, 1'b1, regn, '0, 1'b1);
            return;
          end
        end
      end

      // steal from the farthest end, victim reported as spilled
      if (live_count > 0 && live_end[live_count-1] > fin) begin
        victim = live_temp[live_count-1];
        regn   = live_reg[live_count-1];
        live_count--;
        insert_live(fin, iv.temp_id, regn);
        push(iv.temp_id, 1'b1, regn, '0, 1'b0);
        offset = take_slot();
        push(victim, 1'b0, '0, offset, 1'b1);
        return;
      end

      offset = take_slot();
      push(iv.temp_id, 1'b0, '0, offset, 1'b1);
    endfunction

    function void check_result(assignment_t got);
      assignment_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t unexpected assignment temp=%0d reg=%0d/%0d off=%0d spills=%0d last=%0d",
                   $realtime, got.out_temp, got.has_register, got.register_number,
                   got.slot_offset, got.spills_so_far, got.last);
        return;
      end
      want = expected_q.pop_front();
      if (got.out_temp !== want.out_temp || got.has_register !== want.has_register ||
          got.register_number !== want.register_number ||
          got.slot_offset !== want.slot_offset ||
          got.spills_so_far !== want.spills_so_far || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t assignment mismatch", $realtime);
          $display("  expected temp=%0d reg=%0d/%0d off=%0d spills=%0d last=%0d",
                   want.out_temp, want.has_register, want.register_number,
                   want.slot_offset, want.spills_so_far, want.last);
          $display("  actual   temp=%0d reg=%0d/%0d off=%0d spills=%0d last=%0d",
                   got.out_temp, got.has_register, got.register_number,
                   got.slot_offset, got.spills_so_far, got.last);
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function bit clean();
      if (expected_q.size() != 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0d assignments never arrived", expected_q.size());
      end
      return mismatches == 0;
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // block and channels
  // --------------------------------------------------------------------------
  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  lsra_in_if #(.POSITION_BITS(POS_W)) in_ch ();
  lsra_out_if out_ch ();

  linear_scan_register_assigner DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  lsra_scoreboard sb;
  int unsigned    send_gap_pct;
  int unsigned    stall_pct;
  int             idle_cycles;
  assignment_t    observed;

  // clock
  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  // result side: check each transfer, then stall at random
  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) begin
      observed.out_temp        = out_ch.out_temp;
      observed.has_register    = out_ch.has_register;
      observed.register_number = out_ch.register_number;
      observed.slot_offset     = out_ch.slot_offset;
      observed.spills_so_far   = out_ch.spills_so_far;
      observed.last            = out_ch.last;
      sb.check_result(observed);
    end
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.write_cfg(idx, value);
  endtask

  task automatic write_config(int unsigned count, int unsigned base, int unsigned bytes);
    write_reg(CFG_REG_COUNT, CFG_W'(count));
    write_reg(CFG_BASE_REG, CFG_W'(base));
    write_reg(CFG_SLOT_BYTES, CFG_W'(bytes));
    cfg_we <= 1'b0;
  endtask

  // one interval transfer, with random sender gaps in front
  task automatic send_interval(interval_t iv);
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.begin_function <= iv.begin_function;
    in_ch.eligible       <= iv.eligible;
    in_ch.temp_id        <= iv.temp_id;
    in_ch.def_position   <= iv.def_position;
    in_ch.use_position   <= iv.use_position;
    in_ch.must_spill     <= iv.must_spill;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_interval(iv);
  endtask

  // drain everything, then give intervals without results time to finish
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic interval_t mk(int unsigned b, int unsigned e, int unsigned t,
                                   int unsigned d, int unsigned u, int unsigned s);
    interval_t iv;
    iv.begin_function = 1'(b);
    iv.eligible       = 1'(e);
    iv.temp_id        = TEMP_W'(t);
    iv.def_position   = POS_W'(d);
    iv.use_position   = POS_W'(u);
    iv.must_spill     = 1'(s);
    return iv;
  endfunction

  // well-formed interval starting at the cursor, mostly short lifetimes
  function automatic interval_t shaped_interval(logic opens, logic [POS_W-1:0] at);
    interval_t   iv;
    int unsigned pick;
    int unsigned fin;
    pick = $urandom_range(99);
    fin  = at + ((pick < 70) ? $urandom_range(0, 24) :
                 (pick < 95) ? $urandom_range(0, 300) : $urandom_range(0, POS_MAX));
    if (fin > POS_MAX) fin = POS_MAX;
    iv.begin_function = opens;
    iv.eligible       = ($urandom_range(99) < 90);
    iv.temp_id        = TEMP_W'($urandom);
    iv.def_position   = at;
    iv.use_position   = ($urandom_range(99) < 85) ? POS_W'(fin) : POS_W'($urandom_range(0, at));
    iv.must_spill     = ($urandom_range(99) < 8);
    return iv;
  endfunction

  function automatic interval_t noise_interval();
    return mk(($urandom_range(7) == 0) ? 1 : 0, $urandom_range(1), $urandom, $urandom,
              $urandom, $urandom_range(1));
  endfunction

  // random functions; the first may carry on from the previous phase
  task automatic run_random(int count, bit open_begin);
    interval_t        iv;
    logic [POS_W-1:0] cursor;
    int unsigned      pick;
    int               sent;
    int               len;
    bit               first_fn;
    sent     = 0;
    first_fn = 1'b1;
    while (sent < count) begin
      len  = $urandom_range(3, 40);
      pick = $urandom_range(99);
      cursor = (pick < 50) ? POS_W'($urandom_range(0, 1000)) :
               (pick < 80) ? POS_W'($urandom) : POS_W'(POS_MAX - $urandom_range(0, 200));
      for (int i = 0; i < len && sent < count; i++) begin
        if ($urandom_range(99) < 10) iv = noise_interval();
        else iv = shaped_interval(i == 0 && (open_begin || !first_fn), cursor);
        send_interval(iv);
        sent++;
        cursor = (cursor > POS_MAX - 3) ? POS_W'(POS_MAX)
                                        : POS_W'(cursor + $urandom_range(0, 3));
      end
      first_fn = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    send_gap_pct = 0;
    stall_pct    = 0;
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_REG_COUNT;
    cfg_wdata    <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.begin_function <= 1'b0;
    in_ch.eligible       <= 1'b0;
    in_ch.temp_id        <= '0;
    in_ch.def_position   <= '0;
    in_ch.use_position   <= '0;
    in_ch.must_spill     <= 1'b0;
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: grants, field extremes, ignored intervals, forced spill
    send_interval(mk(1, 1, 0, 0, 0, 0));
    send_interval(mk(0, 1, 4095, 0, POS_MAX, 0));
    send_interval(mk(0, 0, 123, 5, 9, 0));
    send_interval(mk(0, 1, 7, 1, 3, 1));
    send_interval(mk(0, 1, 8, 2, 1, 0));
    send_interval(mk(1, 0, 9, 0, 0, 0));
    send_interval(mk(0, 1, 10, POS_MAX, 0, 0));
    settle();

    // single register: eviction, spill of the newcomer, expiry then grant
    write_config(1, 2, 16);
    send_interval(mk(1, 1, 20, 0, 100, 0));
    send_interval(mk(0, 1, 21, 1, 50, 0));
    send_interval(mk(0, 1, 22, 2, 200, 0));
    send_interval(mk(0, 1, 23, 300, 301, 0));
    settle();

    // zero count and zero slot size act as one; top base register
    write_config(0, 31, 0);
    send_interval(mk(1, 1, 30, 10, 20, 0));
    send_interval(mk(0, 1, 31, 11, 12, 0));
    settle();

    // base moved inside a function: expired register maps out of range
    write_config(0, 0, 0);
    send_interval(mk(0, 1, 32, 100, 110, 0));
    settle();
    write_config(31, 0, 31);
    send_interval(mk(1, 1, 33, 0, 10, 0));
    settle();

    // random functions over the settings table
    for (int p = 0; p < PHASES; p++) begin
      write_config(count_tab[p], base_tab[p], bytes_tab[p]);
      send_gap_pct = gap_tab[p];
      stall_pct    = stall_tab[p];
      run_random(PHASE_ITEMS, p % 2 == 0);
      settle();
    end

    // run of forced spills back to back
    write_config(16, 0, 16);
    send_gap_pct = 0;
    stall_pct    = 0;
    for (int i = 0; i < FLOOD_ITEMS; i++)
      send_interval(mk((i == 0) ? 1 : 0, 1, $urandom, $urandom, $urandom, 1));
    settle();

    if (sb.clean()) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
